FILE: design/mtg_pkg.sv
// Shared constants, types and the tempering function of the MT19937 generator.
package mtg_pkg;

	localparam int unsigned TableLen = 624;
	localparam int unsigned ShiftOfs = 397;
	localparam int unsigned IdxW     = $clog2(TableLen);
	localparam int unsigned WordW    = 32;

	localparam logic [IdxW-1:0] IdxLast  = IdxW'(TableLen - 1);
	localparam logic [IdxW-1:0] FarSplit = IdxW'(TableLen - ShiftOfs);
	localparam logic [IdxW-1:0] FarFwd   = IdxW'(ShiftOfs);

	localparam logic [WordW-1:0] InitMult  = 32'd1812433253;
	localparam logic [WordW-1:0] UpperMask = 32'h8000_0000;
	localparam logic [WordW-1:0] LowerMask = 32'h7fff_ffff;
	localparam logic [WordW-1:0] MatrixA   = 32'h9908_b0df;
	localparam logic [WordW-1:0] TemperB   = 32'h9d2c_5680;
	localparam logic [WordW-1:0] TemperC   = 32'hefc6_0000;
	localparam logic [WordW-1:0] SeedReset = 32'd5489;

	typedef enum logic [3:0] {
		S_FILL_SEED,
		S_FILL_MUL,
		S_FILL_ADD,
		S_IDLE,
		S_RD_CUR,
		S_RD_NXT,
		S_RD_FAR,
		S_CALC,
		S_DELIVER
	} mtg_state_t;

	typedef enum logic [1:0] {
		RA_CUR,
		RA_NXT,
		RA_FAR
	} mtg_rd_sel_t;

	typedef struct packed {
		logic        fill_start;
		logic        fill_reset_seed;
		logic        fill_mul;
		logic        fill_add;
		logic        rd_en;
		mtg_rd_sel_t rd_sel;
		logic        cap_cur;
		logic        cap_nxt;
		logic        calc;
		logic        load_out;
	} mtg_cmd_t;

	typedef struct packed {
		logic            fill_last;
		logic [IdxW-1:0] idx;
	} mtg_sts_t;

	function automatic logic [WordW-1:0] temper(input logic [WordW-1:0] w);
		logic [WordW-1:0] y;
		y = w;
		y = y ^ (y >> 11);
		y = y ^ ((y << 7) & TemperB);
		y = y ^ ((y << 15) & TemperC);
		y = y ^ (y >> 18);
		return y;
	endfunction

endpackage

FILE: design/mtg_ctrl.sv
// Sequencer of the MT19937 generator: fill, twist-and-read steps, output valid.
module mtg_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_stall,
	input  logic            reseed,
	output logic            out_valid,
	input  logic            out_stall,
	input  mtg_pkg::mtg_sts_t sts,
	output mtg_pkg::mtg_cmd_t cmd,
	output mtg_pkg::mtg_state_t state
);
	import mtg_pkg::*;

	mtg_state_t state_q, state_d;
	logic       boot_q;
	logic       out_valid_q;
	logic       out_free;

	assign out_free  = !out_valid_q || !out_stall;
	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;
	assign state     = state_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_FILL_SEED;
			boot_q      <= 1'b1;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == S_FILL_SEED)
				boot_q <= 1'b0;
			if (cmd.load_out)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		cmd.rd_sel = RA_CUR;
		unique case (state_q)
			S_FILL_SEED: begin
				cmd.fill_start      = 1'b1;
				cmd.fill_reset_seed = boot_q;
				state_d             = S_FILL_MUL;
			end
			S_FILL_MUL: begin
				cmd.fill_mul = 1'b1;
				state_d      = S_FILL_ADD;
			end
			S_FILL_ADD: begin
				cmd.fill_add = 1'b1;
				state_d      = sts.fill_last ? S_IDLE : S_FILL_MUL;
			end
			S_IDLE: begin
				if (in_valid)
					state_d = reseed ? S_FILL_SEED : S_RD_CUR;
			end
			S_RD_CUR: begin
				cmd.rd_en  = 1'b1;
				cmd.rd_sel = RA_CUR;
				state_d    = S_RD_NXT;
			end
			S_RD_NXT: begin
				cmd.rd_en   = 1'b1;
				cmd.rd_sel  = RA_NXT;
				cmd.cap_cur = 1'b1;
				state_d     = S_RD_FAR;
			end
			S_RD_FAR: begin
				cmd.rd_en   = 1'b1;
				cmd.rd_sel  = RA_FAR;
				cmd.cap_nxt = 1'b1;
				state_d     = S_CALC;
			end
			S_CALC: begin
				cmd.calc = 1'b1;
				state_d  = S_DELIVER;
			end
			S_DELIVER: begin
				// result waits here while the previous item is still held downstream
				if (out_free) begin
					cmd.load_out = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

endmodule

FILE: design/mtg_datapath.sv
// Datapath of the MT19937 generator: state table, seed fill, twist step, tempering.
module mtg_datapath (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_wr_en,
	input  logic [mtg_pkg::WordW-1:0] cfg_wr_data,
	input  mtg_pkg::mtg_cmd_t        cmd,
	output mtg_pkg::mtg_sts_t        sts,
	output logic [mtg_pkg::WordW-1:0] random_value
);
	import mtg_pkg::*;

	logic [WordW-1:0] table_mem [TableLen];
	logic [WordW-1:0] rdata_q;

	logic [WordW-1:0] seed_q;
	logic [IdxW-1:0]  idx_q;
	logic [IdxW-1:0]  fill_k_q;
	logic [WordW-1:0] prev_q;
	logic [WordW-1:0] prod_q;
	logic [WordW-1:0] cur_q;
	logic [WordW-1:0] nxt_q;
	logic [WordW-1:0] new_q;
	logic [WordW-1:0] out_q;

	logic [WordW-1:0] fill_src;
	logic [WordW-1:0] fill_word;
	logic [WordW-1:0] mix_y;
	logic [WordW-1:0] twist_word;
	logic [IdxW-1:0]  idx_nxt;
	logic [IdxW-1:0]  idx_far;
	logic [IdxW-1:0]  raddr;
	logic             we;
	logic [IdxW-1:0]  waddr;
	logic [WordW-1:0] wdata;

	assign fill_src  = cmd.fill_reset_seed ? SeedReset : seed_q;
	assign fill_word = prod_q + WordW'(fill_k_q);

	assign idx_nxt = (idx_q == IdxLast) ? '0 : idx_q + 1'b1;
	assign idx_far = (idx_q < FarSplit) ? idx_q + FarFwd : idx_q - FarSplit;

	// rdata_q holds the far word during the calc step
	assign mix_y      = (cur_q & UpperMask) | (nxt_q & LowerMask);
	assign twist_word = rdata_q ^ (mix_y >> 1) ^ (mix_y[0] ? MatrixA : '0);

	always_comb begin
		case (cmd.rd_sel)
			RA_NXT:  raddr = idx_nxt;
			RA_FAR:  raddr = idx_far;
			default: raddr = idx_q;
		endcase
	end

	always_comb begin
		we    = 1'b0;
		waddr = idx_q;
		wdata = twist_word;
		if (cmd.fill_start) begin
			we    = 1'b1;
			waddr = '0;
			wdata = fill_src;
		end else if (cmd.fill_add) begin
			we    = 1'b1;
			waddr = fill_k_q;
			wdata = fill_word;
		end else if (cmd.calc) begin
			we = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (we)
			table_mem[waddr] <= wdata;
		if (cmd.rd_en)
			rdata_q <= table_mem[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_q   <= SeedReset;
			idx_q    <= '0;
			fill_k_q <= '0;
		end else begin
			if (cfg_wr_en)
				seed_q <= cfg_wr_data;
			if (cmd.fill_start) begin
				idx_q    <= '0;
				fill_k_q <= IdxW'(1);
			end else if (cmd.fill_add) begin
				fill_k_q <= fill_k_q + 1'b1;
			end else if (cmd.calc) begin
				idx_q <= idx_nxt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.fill_start)
			prev_q <= fill_src;
		else if (cmd.fill_add)
			prev_q <= fill_word;
		if (cmd.fill_mul)
			prod_q <= InitMult * (prev_q ^ (prev_q >> 30));
		if (cmd.cap_cur)
			cur_q <= rdata_q;
		if (cmd.cap_nxt)
			nxt_q <= rdata_q;
		if (cmd.calc)
			new_q <= twist_word;
		if (cmd.load_out)
			out_q <= temper(new_q);
	end

	assign sts.fill_last = (fill_k_q == IdxLast);
	assign sts.idx       = idx_q;
	assign random_value  = out_q;

endmodule

FILE: design/mt19937_generator.sv
// MT19937 generator top level: controller, datapath and checks.
// Input channel: in_valid/in_stall with one field, reseed. reseed = 1 refills the
// 624-word table from the seed register and gives no result; reseed = 0 draws one
// tempered 32-bit word, returned on out_valid/out_stall as random_value.
// The seed register is written through cfg_wr_en/cfg_wr_data; a new seed is only
// used by the next reseed.
// A draw twists one table word (each word once per pass of 624 draws), then tempers
// it. The table has a single read port, so the three words that feed the twist are
// read in turn (current, next, far); the tempered result is loaded into random_value
// once the output register is free, and only then is the next item taken.
// A reseed is one seed write, then a multiply step and an add-and-write step
// for each further word.
// After reset the table is filled from 5489 in the same way; in_stall stays high
// until the fill is done. Configuration writes are taken throughout.
// The output register parts the two sides: while a result is stalled, the next
// item is still accepted and worked on; its result waits until the register frees.
module mt19937_generator (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic                      reseed,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic [mtg_pkg::WordW-1:0] random_value,
	input  logic                      cfg_wr_en,
	input  logic [mtg_pkg::WordW-1:0] cfg_wr_data
);
	import mtg_pkg::*;

	mtg_cmd_t   cmd;
	mtg_sts_t   sts;
	mtg_state_t state;

	mtg_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.reseed    (reseed),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.sts       (sts),
		.cmd       (cmd),
		.state     (state)
	);

	mtg_datapath u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_wr_data  (cfg_wr_data),
		.cmd          (cmd),
		.sts          (sts),
		.random_value (random_value)
	);

`ifndef ASSERT_OFF
	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		sts.idx <= IdxLast)
		else $error("read index beyond table end");

	a_out_from_deliver: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(state == S_DELIVER))
		else $error("result shown without a finished draw");

	a_reseed_fills: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall && reseed) |=> (state == S_FILL_SEED) && in_stall)
		else $error("reseed item did not start a table fill");

	a_fill_holds_input: assert property (@(posedge clk) disable iff (!arst_n)
		(state == S_FILL_ADD && !sts.fill_last) |=> in_stall && !cmd.load_out)
		else $error("item taken or result loaded during table fill");
`endif

endmodule

FILE: tb/testbench.sv
// Self-checking testbench for mt19937_generator: directed table, then random draw and reseed runs.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import mtg_pkg::*;

	localparam int unsigned TblDepth   = 624;
	localparam int unsigned TwistOfs   = 397;
	localparam logic [31:0] SeedMult   = 32'd1812433253;
	localparam logic [31:0] HiMask     = 32'h8000_0000;
	localparam logic [31:0] LoMask     = 32'h7fff_ffff;
	localparam logic [31:0] TwistXor   = 32'h9908_b0df;
	localparam logic [31:0] TempMaskB  = 32'h9d2c_5680;
	localparam logic [31:0] TempMaskC  = 32'hefc6_0000;
	localparam logic [31:0] PowerSeed  = 32'd5489;
	localparam bit          OpDraw     = 1'b0;
	localparam bit          OpRefill   = 1'b1;
	localparam int unsigned FillCycles = 1300;
	localparam int unsigned DrainCycles = 50;
	localparam int unsigned HoldCycles = 400;
	localparam int unsigned RandItems  = 1200;
	localparam int unsigned CycleLimit = 600_000;

	logic             clk = 1'b0;
	logic             arst_n;
	logic             in_valid;
	logic             in_stall;
	logic             reseed;
	logic             out_valid;
	logic             out_stall;
	logic [WordW-1:0] random_value;
	logic             cfg_wr_en;
	logic [WordW-1:0] cfg_wr_data;

	mt19937_generator uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.reseed       (reseed),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.random_value (random_value),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_wr_data  (cfg_wr_data)
	);

	always #6 clk = ~clk;

	// predictor state
	logic [31:0] mt_words [TblDepth];
	int unsigned mt_pos;
	logic [31:0] mt_seed;

	logic [31:0] draw_q [$];
	int unsigned mismatches = 0;
	int unsigned draws_seen = 0;
	int unsigned cycles = 0;
	bit          src_fast = 1'b0;
	bit          sink_fast = 1'b0;

	function automatic void mt_fill(input logic [31:0] s);
		mt_words[0] = s;
		for (int k = 1; k < TblDepth; k++)
			mt_words[k] = SeedMult * (mt_words[k-1] ^ (mt_words[k-1] >> 30)) + 32'(k);
		mt_pos = 0;
	endfunction

	function automatic void mt_twist();
		logic [31:0] y;
		logic [31:0] v;
		for (int k = 0; k < TblDepth; k++) begin
			y = (mt_words[k] & HiMask) | (mt_words[(k + 1) % TblDepth] & LoMask);
			v = mt_words[(k + TwistOfs) % TblDepth] ^ (y >> 1);
			if (y[0]) begin
				v = v ^ TwistXor;
			end
			mt_words[k] = v;
		end
	endfunction

	function automatic logic [31:0] mt_draw();
		logic [31:0] t;
		if (mt_pos >= TblDepth) begin
			mt_pos = 0;
		end
		if (mt_pos == 0) begin
			mt_twist();
		end
		t = mt_words[mt_pos];
		mt_pos++;
		t = t ^ (t >> 11);
		t = t ^ ((t << 7) & TempMaskB);
		t = t ^ ((t << 15) & TempMaskC);
		t = t ^ (t >> 18);
		return t;
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] want,
			input logic [31:0] got);
		$display("MISMATCH %s: expected %h, got %h (cycle %0d)", what, want, got, cycles);
		mismatches++;
	endtask

	// wait for the block to go quiet: all draws back, then time for a refill to finish
	task automatic wait_quiet();
		in_valid <= 1'b0;
		while (draw_q.size() != 0) @(posedge clk);
		repeat (FillCycles) @(posedge clk);
	endtask

	task automatic write_seed(input logic [31:0] v);
		wait_quiet();
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= v;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		mt_seed = v;
	endtask

	task automatic send_item(input bit op, input bit known, input logic [31:0] known_val);
		int unsigned gap;
		logic [31:0] want;
		gap = src_fast ? 0 : $urandom_range(0, 11);
		if ($urandom_range(0, 39) == 0)
			src_fast = ~src_fast;
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		reseed   <= op;
		do @(posedge clk); while (in_stall);
		if (op == OpRefill) begin
			mt_fill(mt_seed);
		end else begin
			want = mt_draw();
			draw_q.push_back(known ? known_val : want);
		end
	endtask

	// result side: random stalls, one long hold-off to back the block up
	initial begin
		int unsigned gap;
		bit held;
		held = 1'b0;
		out_stall <= 1'b0;
		@(posedge clk);
		forever begin
			gap = sink_fast ? 0 : $urandom_range(0, 11);
			if ($urandom_range(0, 39) == 0)
				sink_fast = ~sink_fast;
			if (!held && draws_seen >= 200) begin
				gap  = HoldCycles;
				held = 1'b1;
			end
			if (gap != 0) begin
				out_stall <= 1'b1;
				repeat (gap) @(posedge clk);
			end
			out_stall <= 1'b0;
			do @(posedge clk); while (!out_valid);
		end
	end

	always @(posedge clk) begin : check_draws
		logic [31:0] want;
		if (arst_n && out_valid && !out_stall) begin
			draws_seen++;
			if (draw_q.size() == 0) begin
				report_mismatch("random_value with no draw pending", 'x, random_value);
			end else begin
				want = draw_q.pop_front();
				if (random_value !== want)
					report_mismatch("random_value", want, random_value);
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CycleLimit) begin
			$display("TIMEOUT after %0d cycles, %0d draws outstanding", cycles, draw_q.size());
			$display("mt19937_generator verification failed");
			$finish;
		end
	end

	typedef struct {
		bit          set_seed;
		logic [31:0] seed_val;
		bit          op;
		bit          known;
		logic [31:0] known_val;
	} stim_row_t;

	stim_row_t dir_rows [] = '{
		// power-on table from the default seed
		'{1'b0, 32'h0,         OpDraw,   1'b1, 32'd3499211612},
		'{1'b0, 32'h0,         OpDraw,   1'b1, 32'd581869302},
		'{1'b0, 32'h0,         OpDraw,   1'b1, 32'd3890346734},
		'{1'b0, 32'h0,         OpDraw,   1'b1, 32'd3586334585},
		'{1'b0, 32'h0,         OpDraw,   1'b1, 32'd545404204},
		// new seed without a reseed: the sequence carries on
		'{1'b1, 32'hffff_ffff, OpDraw,   1'b0, 32'h0},
		'{1'b0, 32'h0,         OpRefill, 1'b0, 32'h0},
		'{1'b0, 32'h0,         OpDraw,   1'b0, 32'h0},
		'{1'b0, 32'h0,         OpDraw,   1'b0, 32'h0},
		'{1'b1, 32'h0,         OpRefill, 1'b0, 32'h0},
		'{1'b0, 32'h0,         OpDraw,   1'b0, 32'h0},
		'{1'b0, 32'h0,         OpDraw,   1'b0, 32'h0},
		'{1'b1, PowerSeed,     OpRefill, 1'b0, 32'h0},
		'{1'b0, 32'h0,         OpDraw,   1'b1, 32'd3499211612},
		'{1'b0, 32'h0,         OpDraw,   1'b1, 32'd581869302},
		// back-to-back reseeds
		'{1'b0, 32'h0,         OpRefill, 1'b0, 32'h0},
		'{1'b0, 32'h0,         OpRefill, 1'b0, 32'h0},
		'{1'b0, 32'h0,         OpDraw,   1'b1, 32'd3499211612},
		'{1'b1, 32'd1,         OpRefill, 1'b0, 32'h0},
		'{1'b0, 32'h0,         OpDraw,   1'b1, 32'd1791095845},
		'{1'b0, 32'h0,         OpDraw,   1'b1, 32'd4282876139},
		'{1'b1, 32'h8000_0000, OpRefill, 1'b0, 32'h0},
		'{1'b0, 32'h0,         OpDraw,   1'b0, 32'h0}
	};

	initial begin
		int unsigned sent;
		int unsigned phase;
		int unsigned run_len;
		logic [31:0] nv;
		arst_n      <= 1'b0;
		in_valid    <= 1'b0;
		reseed      <= OpDraw;
		cfg_wr_en   <= 1'b0;
		cfg_wr_data <= '0;
		mt_seed = PowerSeed;
		mt_fill(mt_seed);
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		foreach (dir_rows[i]) begin
			if (dir_rows[i].set_seed)
				write_seed(dir_rows[i].seed_val);
			send_item(dir_rows[i].op, dir_rows[i].known, dir_rows[i].known_val);
		end

		sent  = 0;
		phase = 0;
		while (sent < RandItems) begin
			case (phase)
				0: nv = 32'h0;
				1: nv = 32'hffff_ffff;
				default: nv = $urandom();
			endcase
			if (phase < 2 || $urandom_range(0, 3) != 0)
				write_seed(nv);
			else
				wait_quiet();
			if (phase == 0 || $urandom_range(0, 4) != 0) begin
				send_item(OpRefill, 1'b0, 32'h0);
				sent++;
			end
			// first phase runs clean past the end of the table so the index wraps
			run_len = (phase == 0) ? 650 : $urandom_range(20, 150);
			for (int n = 0; n < run_len; n++) begin
				if (phase != 0 && $urandom_range(0, 59) == 0)
					send_item(OpRefill, 1'b0, 32'h0);
				else
					send_item(OpDraw, 1'b0, 32'h0);
				sent++;
			end
			phase++;
		end

		in_valid <= 1'b0;
		while (draw_q.size() != 0) @(posedge clk);
		repeat (DrainCycles) @(posedge clk);
		if (mismatches == 0)
			$display("mt19937_generator verification clean");
		else
			$display("mt19937_generator verification failed");
		$finish;
	end

endmodule
